// File: hw/rtl/bitmap_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// types and constants shared by the bitmap page allocator files
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	// payload widths
	localparam int CMD_W   = 2;
	localparam int ADDR_W  = 24;
	localparam int CNT_W   = 13;
	localparam int ST_W    = 2;
	localparam int LIMIT_W = 13;

	// reset value of the page limit register
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

	// byte pattern of eight used pages
	localparam logic [7:0] BYTE_ALL_USED = 8'hFF;

	// request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_RESERVE = 2'd2
	} cmd_t;

	// response status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_BAD    = 2'd2,
		ST_BEYOND = 2'd3
	} stat_t;

	// request class after decode
	typedef enum logic [1:0] {
		KIND_BAD,
		KIND_ALLOC,
		KIND_MARK,
		KIND_DONE
	} kind_t;

	// controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MARK_RD,
		S_MARK_WR,
		S_RESP
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clr_wr;
		logic load;
		logic decode;
		logic scan_en;
		logic mark_rd;
		logic mark_wr;
		logic rsp_push;
	} bpa_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic  clr_last;
		kind_t kind;
		logic  found;
		logic  scan_end;
		logic  mark_last;
		logic  rsp_busy;
	} bpa_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpa_if.sv
// ----------------------------------------------------------------------------
// bpa_if
// valid/ready channels of the bitmap page allocator
// ----------------------------------------------------------------------------
`default_nettype none

// allocate, free and reserve requests
interface bpa_req_if;
	import bpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [ADDR_W-1:0] page_address;
	logic [CNT_W-1:0]  page_count;

	modport source (output valid, command, page_address, page_count, input ready);
	modport sink (input valid, command, page_address, page_count, output ready);
endinterface

// one response per request
interface bpa_rsp_if;
	import bpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [ADDR_W-1:0] result_address;

	modport source (output valid, status, result_address, input ready);
	modport sink (input valid, status, result_address, output ready);
endinterface

// page limit register write
interface bpa_cfg_if;
	import bpa_pkg::*;

	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] page_limit;

	modport source (output valid, page_limit, input ready);
	modport sink (input valid, page_limit, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// sequencer for clearing, scanning, run marking and response hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_page_allocator_macros.svh"

module bpa_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  bpa_pkg::bpa_sts_t   sts,
	output bpa_pkg::bpa_ctl_t   ctl
);
	import bpa_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				ctl.decode = 1'b1;
				unique case (sts.kind)
					KIND_ALLOC: state_d = S_SCAN;
					KIND_MARK:  state_d = S_MARK_RD;
					default:    state_d = S_RESP;
				endcase
			end
			S_SCAN: begin
				ctl.scan_en = 1'b1;
				if (sts.found) begin
					state_d = S_MARK_RD;
				end else if (sts.scan_end) begin
					state_d = S_RESP;
				end
			end
			S_MARK_RD: begin
				ctl.mark_rd = 1'b1;
				state_d     = S_MARK_WR;
			end
			S_MARK_WR: begin
				ctl.mark_wr = 1'b1;
				state_d     = sts.mark_last ? S_RESP : S_MARK_RD;
			end
			S_RESP: begin
				if (!sts.rsp_busy) begin
					ctl.rsp_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	`BPA_ASSERT_IMPL(a_one_command, 1'b1, $onehot0(ctl), "more than one datapath command")
	`BPA_ASSERT_NEXT(a_push_then_idle, ctl.rsp_push, state_q == S_IDLE, "no return to idle")
	`BPA_ASSERT_NEXT(a_load_then_decode, ctl.load, state_q == S_DECODE, "no decode after load")

endmodule

`default_nettype wire

// File: hw/rtl/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// page bitmap memory, byte-wide first-fit scan, run marking, response register
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_page_allocator_macros.svh"

module bpa_dp #(
	parameter int NUM_PAGES  = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [bpa_pkg::CMD_W-1:0]    req_command,
	input  wire  [bpa_pkg::ADDR_W-1:0]   req_page_address,
	input  wire  [bpa_pkg::CNT_W-1:0]    req_page_count,
	input  bpa_pkg::bpa_ctl_t            ctl,
	output bpa_pkg::bpa_sts_t            sts,
	bpa_rsp_if.source                    rsp,
	bpa_cfg_if.sink                      cfg
);
	import bpa_pkg::*;

	// derived sizes
	localparam int PB_LOG = $clog2(PAGE_BYTES);
	localparam int SPW    = ADDR_W - PB_LOG;
	localparam int NB     = (NUM_PAGES + 7) / 8;
	localparam int BAW    = (NB > 1) ? $clog2(NB) : 1;
	localparam int PW     = BAW + 3;
	localparam int PIW    = $clog2(NUM_PAGES);
	localparam int PCW    = $clog2(NUM_PAGES + 1);
	localparam int CW0    = (SPW > CNT_W) ? SPW : CNT_W;
	localparam int CW1    = (CW0 > PW) ? CW0 : PW;
	localparam int CW2    = (CW1 > PCW) ? CW1 : PCW;
	localparam int CW     = ((CW2 > LIMIT_W) ? CW2 : LIMIT_W) + 1;
	localparam int SHW    = PIW + PB_LOG;
	localparam logic [BAW-1:0] LAST_BYTE = BAW'(NB - 1);

	// page bitmap, one bit per page, eight pages a byte
	logic [7:0] mem [NB];

	logic [LIMIT_W-1:0] page_limit_q;
	logic [CMD_W-1:0]   req_cmd_q;
	logic [ADDR_W-1:0]  req_addr_q;
	logic [CNT_W-1:0]   req_cnt_q;
	logic [BAW-1:0]     clr_q;
	logic [BAW-1:0]     rd_b_q;
	logic [BAW-1:0]     scan_b_s1;
	logic               scan_v_s1;
	logic [CNT_W-1:0]   run_q;
	logic [PIW-1:0]     rs_q;
	logic [BAW-1:0]     mb_q;
	logic [PCW-1:0]     lo_q;
	logic [PCW-1:0]     hi_q;
	logic               mval_q;
	stat_t              st_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic [7:0]         rd_data_q;
	logic               rsp_v_q;
	logic [ST_W-1:0]    rsp_st_q;
	logic [ADDR_W-1:0]  rsp_addr_q;

	logic [SPW-1:0]     start_c;
	logic [CW-1:0]      sum_c;
	logic [CW-1:0]      lim_c;
	logic               misaligned_c;
	logic               beyond_c;
	logic               in_store_c;
	kind_t              kind_c;
	logic [CW-1:0]      hi_clamp_c;
	logic [CNT_W-1:0]   run_c;
	logic [PIW-1:0]     rs_c;
	logic               found_c;
	logic               end_c;
	logic [SHW-1:0]     base_c;
	logic [PCW-1:0]     hi_m1_c;
	logic [BAW-1:0]     last_b_c;
	logic [7:0]         mask_c;
	logic [7:0]         wr_data_c;
	logic [BAW-1:0]     rd_addr_c;
	logic [BAW-1:0]     wr_addr_c;
	logic               rd_en_c;
	logic               wr_en_c;

	// request decode
	always_comb begin
		start_c      = req_addr_q[ADDR_W-1:PB_LOG];
		misaligned_c = |req_addr_q[PB_LOG-1:0];
		sum_c        = CW'(start_c) + CW'(req_cnt_q);
		beyond_c     = (req_cnt_q != '0) && (sum_c > CW'(NUM_PAGES));
		in_store_c   = CW'(start_c) < CW'(NUM_PAGES);
		hi_clamp_c   = beyond_c ? CW'(NUM_PAGES) : sum_c;
		unique case (req_cmd_q) inside
			CMD_ALLOC: begin
				kind_c = (req_cnt_q == '0) ? KIND_BAD : KIND_ALLOC;
			end
			CMD_FREE, CMD_RESERVE: begin
				if (misaligned_c) begin
					kind_c = KIND_BAD;
				end else if ((req_cnt_q == '0) || !in_store_c) begin
					kind_c = KIND_DONE;
				end else begin
					kind_c = KIND_MARK;
				end
			end
			default: begin
				kind_c = KIND_BAD;
			end
		endcase
	end

	// search bound, clamped to the store
	assign lim_c = (CW'(page_limit_q) < CW'(NUM_PAGES)) ? CW'(page_limit_q) : CW'(NUM_PAGES);

	// run tracking over the eight pages of the fetched byte
	always_comb begin
		logic [PW-1:0] p;
		logic          pv;
		run_c   = run_q;
		rs_c    = rs_q;
		found_c = 1'b0;
		for (int k = 0; k < 8; k++) begin
			p  = {scan_b_s1, 3'(k)};
			pv = (p != '0) && (CW'(p) < lim_c);
			if (!found_c && pv) begin
				if (!rd_data_q[k]) begin
					if (run_c == '0) begin
						rs_c = PIW'(p);
					end
					run_c = run_c + CNT_W'(1);
					if (run_c == req_cnt_q) begin
						found_c = 1'b1;
					end
				end else begin
					run_c = '0;
				end
			end
		end
		end_c  = (CW'({scan_b_s1, 3'b000}) + CW'(8)) >= lim_c;
		base_c = SHW'(rs_c) << PB_LOG;
	end

	// pages of the current byte inside the marked run
	always_comb begin
		logic [PW-1:0] p;
		for (int k = 0; k < 8; k++) begin
			p         = {mb_q, 3'(k)};
			mask_c[k] = (CW'(p) >= CW'(lo_q)) && (CW'(p) < CW'(hi_q));
		end
		hi_m1_c   = hi_q - PCW'(1);
		last_b_c  = BAW'(hi_m1_c >> 3);
		wr_data_c = ctl.clr_wr ? BYTE_ALL_USED
			: ((rd_data_q & ~mask_c) | (mval_q ? mask_c : 8'h00));
	end

	// memory port selection
	assign rd_en_c   = ctl.scan_en || ctl.mark_rd;
	assign rd_addr_c = ctl.scan_en ? rd_b_q : mb_q;
	assign wr_en_c   = ctl.clr_wr || ctl.mark_wr;
	assign wr_addr_c = ctl.clr_wr ? clr_q : mb_q;

	// bitmap memory
	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			mem[wr_addr_c] <= wr_data_c;
		end
		if (rd_en_c) begin
			rd_data_q <= mem[rd_addr_c];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= LIMIT_RESET;
			clr_q        <= '0;
			scan_v_s1    <= 1'b0;
			rsp_v_q      <= 1'b0;
		end else begin
			if (cfg.valid) begin
				page_limit_q <= cfg.page_limit;
			end
			if (ctl.clr_wr) begin
				clr_q <= clr_q + BAW'(1);
			end
			if (ctl.decode) begin
				scan_v_s1 <= 1'b0;
			end else if (ctl.scan_en) begin
				scan_v_s1 <= 1'b1;
			end
			if (ctl.rsp_push) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	// request, scan and mark payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_cmd_q  <= req_command;
			req_addr_q <= req_page_address;
			req_cnt_q  <= req_page_count;
		end
		if (ctl.decode) begin
			res_addr_q <= '0;
			rd_b_q     <= '0;
			run_q      <= '0;
			mval_q     <= (req_cmd_q != CMD_FREE);
			lo_q       <= PCW'(start_c);
			hi_q       <= PCW'(hi_clamp_c);
			mb_q       <= BAW'(start_c >> 3);
			unique case (kind_c)
				KIND_BAD:   st_q <= ST_BAD;
				KIND_ALLOC: st_q <= ST_OK;
				default:    st_q <= beyond_c ? ST_BEYOND : ST_OK;
			endcase
		end
		if (ctl.scan_en) begin
			scan_b_s1 <= rd_b_q;
			if (rd_b_q != LAST_BYTE) begin
				rd_b_q <= rd_b_q + BAW'(1);
			end
			if (scan_v_s1) begin
				run_q <= run_c;
				rs_q  <= rs_c;
				if (found_c) begin
					lo_q       <= PCW'(rs_c);
					hi_q       <= PCW'(CW'(rs_c) + CW'(req_cnt_q));
					mb_q       <= BAW'(rs_c >> 3);
					res_addr_q <= ADDR_W'(base_c);
				end else if (end_c) begin
					st_q <= ST_NOFIT;
				end
			end
		end
		if (ctl.mark_wr) begin
			mb_q <= mb_q + BAW'(1);
		end
		if (ctl.rsp_push) begin
			rsp_st_q   <= st_q;
			rsp_addr_q <= res_addr_q;
		end
	end

	// status toward the controller
	always_comb begin
		sts.clr_last  = (clr_q == LAST_BYTE);
		sts.kind      = kind_c;
		sts.found     = ctl.scan_en && scan_v_s1 && found_c;
		sts.scan_end  = ctl.scan_en && scan_v_s1 && end_c;
		sts.mark_last = (mb_q == last_b_c);
		sts.rsp_busy  = rsp_v_q && !rsp.ready;
	end

	// ports
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = rsp_v_q;
	assign rsp.status         = rsp_st_q;
	assign rsp.result_address = rsp_addr_q;

	`BPA_ASSERT_IMPL(a_mark_after_read, ctl.mark_wr, $past(ctl.mark_rd), "write without read")
	`BPA_ASSERT_IMPL(a_push_free, ctl.rsp_push, !rsp_v_q || rsp.ready, "response overwritten")
	`BPA_ASSERT_IMPL(a_scan_alloc, ctl.scan_en, req_cmd_q == CMD_ALLOC, "scan on non-alloc")

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// free/reserve: decode, then a read and a write per bitmap byte touched, then the response
// alloc: decode, a scan of 8 pages a cycle over the bitmap bytes, then marking as above
// bad or empty requests go from decode straight to the response; one request in flight at a time
// reset: all pages marked used by a clearing pass over every bitmap byte,
// during which no request is taken; page_limit resets to 4096
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator #(
	parameter int NUM_PAGES  = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  wire        clk,
	input  wire        arst_n,
	bpa_req_if.sink    req,
	bpa_rsp_if.source  rsp,
	bpa_cfg_if.sink    cfg
);
	import bpa_pkg::*;

	bpa_ctl_t ctl;
	bpa_sts_t sts;
	logic     req_ready;

	// request handshake
	assign req.ready = req_ready;

	// sequencer
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// bitmap datapath
	bpa_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_command      (req.command),
		.req_page_address (req.page_address),
		.req_page_count   (req.page_count),
		.ctl              (ctl),
		.sts              (sts),
		.rsp              (rsp),
		.cfg              (cfg)
	);

endmodule

`default_nettype wire

// File: dv/bitmap_page_allocator_tb.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb
// self-checking bench for the first-fit page allocator; a bit-level copy of
// the used/free map predicts status and base address of every request and
// each response is checked in order; directed requests on the full map,
// malformed requests, store edges and limit extremes, then four random phases
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	localparam int unsigned NUM_PAGES   = 4096;
	localparam int unsigned PAGE_BYTES  = 4096;
	localparam longint      CYCLE_LIMIT = 8_000_000;

	// command code that the block does not know
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct {
		stat_t             status;
		logic [ADDR_W-1:0] address;
	} outcome_t;

	typedef struct {
		int unsigned page;
		int unsigned count;
	} page_run_t;

	logic clk;
	logic arst_n;

	bpa_req_if req_ch ();
	bpa_rsp_if rsp_ch ();
	bpa_cfg_if cfg_ch ();

	// local copy of the allocator state
	bit          page_used [NUM_PAGES];
	int unsigned managed_limit;

	outcome_t  pending_outcomes [$];
	page_run_t granted_runs [$];

	int     error_count;
	int     requests_sent;
	int     replies_checked;
	int     status_seen [4];
	longint cycle_count;
	int     req_idle_pct;
	int     rsp_stall_pct;

	bitmap_page_allocator #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycle_count, pending_outcomes.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// response backpressure
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic logic [ADDR_W-1:0] page_base(input int unsigned page);
		return ADDR_W'(page * PAGE_BYTES);
	endfunction

	// apply one request to the local map and return status and address
	function automatic outcome_t apply_page_request(input logic [CMD_W-1:0] command,
		input logic [ADDR_W-1:0] address, input logic [CNT_W-1:0] count);
		outcome_t    res;
		int unsigned search_end;
		int unsigned run_len;
		int unsigned first_free;
		int unsigned first_page;
		int unsigned p;
		bit          skipped;

		res.status  = ST_BAD;
		res.address = '0;
		run_len     = 0;
		first_free  = 0;
		skipped     = 1'b0;
		search_end  = (managed_limit < NUM_PAGES) ? managed_limit : NUM_PAGES;
		case (command)
			CMD_ALLOC: begin
				// first fit over pages 1 .. limit-1 within the store, page 0 never granted
				if (count != 0) begin
					res.status = ST_NOFIT;
					for (int unsigned i = 1; i < search_end; i++) begin
						if (!page_used[i]) begin
							if (run_len == 0)
								first_free = i;
							run_len++;
							if (run_len == count) begin
								for (int unsigned j = 0; j < count; j++)
									page_used[first_free + j] = 1'b1;
								res.status  = ST_OK;
								res.address = page_base(first_free);
								granted_runs.push_back('{first_free, count});
								break;
							end
						end else begin
							run_len = 0;
						end
					end
				end
			end
			CMD_FREE, CMD_RESERVE: begin
				// aligned runs only; pages past the store are dropped
				if (address % PAGE_BYTES == 0) begin
					first_page = address / PAGE_BYTES;
					for (int unsigned i = 0; i < count; i++) begin
						p = first_page + i;
						if (p < NUM_PAGES)
							page_used[p] = (command == CMD_RESERVE);
						else
							skipped = 1'b1;
					end
					res.status = skipped ? ST_BEYOND : ST_OK;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// send one request and record its predicted reply
	task automatic issue_request(input logic [CMD_W-1:0] command,
		input logic [ADDR_W-1:0] address, input logic [CNT_W-1:0] count);
		@(negedge clk);
		while ($urandom_range(0, 99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.command      <= command;
		req_ch.page_address <= address;
		req_ch.page_count   <= count;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_outcomes.push_back(apply_page_request(command, address, count));
		requests_sent++;
	endtask

	// stop requests and let every reply come back
	task automatic wait_quiet(input int settle);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_page_limit(input logic [LIMIT_W-1:0] value);
		wait_quiet(8);
		@(negedge clk);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.page_limit <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		managed_limit = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly small counts, a few up to the whole store
	function automatic logic [CNT_W-1:0] pick_count();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 70)
			return CNT_W'($urandom_range(1, 8));
		else if (r < 90)
			return CNT_W'($urandom_range(9, 64));
		else if (r < 98)
			return CNT_W'($urandom_range(65, 512));
		return CNT_W'($urandom_range(513, NUM_PAGES));
	endfunction

	// reply checker
	always @(posedge clk) begin : check_replies
		outcome_t want;

		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("reply with no request: status %0d address %06h",
					rsp_ch.status, rsp_ch.result_address));
			end else begin
				want = pending_outcomes.pop_front();
				replies_checked++;
				status_seen[want.status]++;
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("reply %0d status %0d, want %0d",
						replies_checked, rsp_ch.status, want.status));
				if (rsp_ch.result_address !== want.address)
					report_mismatch($sformatf("reply %0d address %06h, want %06h",
						replies_checked, rsp_ch.result_address, want.address));
			end
		end
	end

	// full map after reset and malformed requests
	task automatic test_empty_map();
		issue_request(CMD_ALLOC, 24'h000000, 13'd1);
		issue_request(CMD_ALLOC, 24'hFFFFFF, 13'd0);
		issue_request(CMD_UNKNOWN, 24'h123000, 13'd4);
		issue_request(CMD_FREE, 24'h000801, 13'd4);
		issue_request(CMD_RESERVE, 24'hFFFFFF, 13'd1);
		issue_request(CMD_FREE, 24'h000000, 13'd0);
	endtask

	// first fit skips page 0 and used pages
	task automatic test_first_fit();
		issue_request(CMD_FREE, 24'h000000, 13'd64);
		issue_request(CMD_ALLOC, 24'hABCDEF, 13'd1);
		issue_request(CMD_ALLOC, 24'h000000, 13'd8);
		issue_request(CMD_RESERVE, 24'h00A000, 13'd1);
		issue_request(CMD_ALLOC, 24'h000000, 13'd4);
	endtask

	// runs that cross the top of the store, and whole-store runs
	task automatic test_store_edges();
		issue_request(CMD_FREE, 24'hFFF000, 13'd4);
		issue_request(CMD_RESERVE, 24'hFFE000, 13'd4096);
		issue_request(CMD_FREE, 24'h000000, 13'd4096);
		issue_request(CMD_ALLOC, 24'h000000, 13'd4095);
		issue_request(CMD_ALLOC, 24'h000000, 13'd1);
		issue_request(CMD_FREE, 24'hFFF000, 13'd1);
		issue_request(CMD_ALLOC, 24'h000000, 13'd1);
	endtask

	// limit of 0, 1, 2 and above the store
	task automatic test_page_limit();
		write_page_limit(13'd0);
		issue_request(CMD_FREE, 24'h000000, 13'd16);
		issue_request(CMD_ALLOC, 24'h000000, 13'd1);
		write_page_limit(13'd1);
		issue_request(CMD_ALLOC, 24'h000000, 13'd1);
		write_page_limit(13'd2);
		issue_request(CMD_ALLOC, 24'h000000, 13'd2);
		issue_request(CMD_ALLOC, 24'h000000, 13'd1);
		write_page_limit(13'h1FFF);
		issue_request(CMD_FREE, 24'hFFC000, 13'd4);
		issue_request(CMD_ALLOC, 24'h000000, 13'd14);
		issue_request(CMD_ALLOC, 24'h000000, 13'd4);
	endtask

	// random mix of allocations, frees of granted runs, reserves and noise
	task automatic test_random_traffic(input logic [LIMIT_W-1:0] limit, input int idle_pct,
		input int stall_pct, input int n_items);
		int unsigned       pick;
		int unsigned       idx;
		int unsigned       search_pages;
		page_run_t         run_pick;
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  cnt;

		write_page_limit(limit);
		req_idle_pct  = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int k = 0; k < n_items; k++) begin
			if (managed_limit < 2 || managed_limit > NUM_PAGES)
				search_pages = NUM_PAGES;
			else
				search_pages = managed_limit;
			pick = $urandom_range(0, 99);
			addr = ADDR_W'($urandom());
			cnt  = pick_count();
			cmd  = CMD_ALLOC;
			if (pick < 45) begin
				cmd = CMD_ALLOC;
			end else if (pick < 75) begin
				// mostly hand back a run that was granted earlier
				cmd = CMD_FREE;
				if (granted_runs.size() != 0 && $urandom_range(0, 99) < 70) begin
					idx      = $urandom_range(0, granted_runs.size() - 1);
					run_pick = granted_runs[idx];
					granted_runs.delete(idx);
					addr = page_base(run_pick.page);
					cnt  = CNT_W'(run_pick.count);
				end else begin
					addr = page_base($urandom_range(0, search_pages - 1));
				end
			end else if (pick < 90) begin
				cmd  = CMD_RESERVE;
				addr = page_base($urandom_range(0, search_pages - 1));
			end else begin
				// malformed and edge requests
				cmd = $urandom_range(0, 1) ? CMD_FREE : CMD_RESERVE;
				case (pick % 5)
					0: begin
						cmd = CMD_UNKNOWN;
						cnt = CNT_W'($urandom_range(0, NUM_PAGES));
					end
					1: addr[11:0] = 12'($urandom_range(1, 4095));
					2: begin
						cmd = CMD_ALLOC;
						cnt = '0;
					end
					3: cnt = '0;
					default: begin
						addr = page_base($urandom_range(NUM_PAGES - 64, NUM_PAGES - 1));
						cnt  = CNT_W'($urandom_range(1, 256));
					end
				endcase
			end
			issue_request(cmd, addr, cnt);
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.command      = CMD_ALLOC;
		req_ch.page_address = '0;
		req_ch.page_count   = '0;
		rsp_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.page_limit   = '0;
		managed_limit       = LIMIT_RESET;
		req_idle_pct        = 12;
		rsp_stall_pct       = 12;
		foreach (page_used[i])
			page_used[i] = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_map();
		test_first_fit();
		test_store_edges();
		test_page_limit();
		test_random_traffic(13'd4096, 0, 0, 270);
		test_random_traffic(13'd1024, 79, 0, 270);
		test_random_traffic(13'h1FFF, 0, 79, 270);
		test_random_traffic(13'd200, 12, 12, 270);

		wait_quiet(16);
		$display("covered %0d requests, %0d replies: ok %0d, no fit %0d, bad %0d, beyond %0d",
			requests_sent, replies_checked, status_seen[ST_OK], status_seen[ST_NOFIT],
			status_seen[ST_BAD], status_seen[ST_BEYOND]);
		$display("page limits 0, 1, 2, 200, 1024, 4096 and 8191 under four idle patterns");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
